// ===== src/elgamal_cipher_engine_defines.svh =====
// Assertion macros used by the checker file of the ElGamal engine.
// Depends on nothing; included by the checker module.
`ifndef ELGAMAL_CIPHER_ENGINE_DEFINES_SVH
`define ELGAMAL_CIPHER_ENGINE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define EGC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("engine assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define EGC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("engine assertion failed");

`endif

// ===== src/egc_pkg.sv =====
// Package of the ElGamal engine: sequencer state and phase types, register
// indexes, command codes and reset constants. Depends on nothing.
package egc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_GENERATOR   = 2'd1;
    localparam logic [1:0] REG_PUBLIC_KEY  = 2'd2;
    localparam logic [1:0] REG_PRIVATE_KEY = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [31:0] RESET_MODULUS     = 32'd7879;
    localparam logic [31:0] RESET_GENERATOR   = 32'd2;
    localparam logic [31:0] RESET_PUBLIC_KEY  = 32'd1;
    localparam logic [31:0] RESET_PRIVATE_KEY = 32'd1;

    // Command codes.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_MSG,
        ST_RED_BASE,
        ST_POW_TEST,
        ST_POW_ACC,
        ST_POW_SQ,
        ST_FIN_MUL,
        ST_DONE
    } state_t;

    // Which exponentiation is in progress.
    typedef enum logic [1:0] {
        PH_ENC_G,
        PH_ENC_Y,
        PH_DEC_S,
        PH_DEC_INV
    } phase_t;

endpackage

// ===== src/elgamal_cipher_engine.sv =====
// Top level of the ElGamal engine: configuration registers, sequencer and
// output register. Depends on egc_pkg and egc_modmul.
//
// Usage: write modulus, generator, public key and private key through the
// cfg_wr_en / cfg_index / cfg_data port while the engine is idle. A request on
// the input channel (in_valid, in_stall) carries an encrypt or decrypt
// command. The engine takes one request at a time and holds in_stall high
// until its work is finished. Each step is a modular multiplication in the
// bit-serial multiplier, which sets the pace: an item needs at most
// 4 * MOD_BITS + 4 multiplications plus a test step per exponent bit. A
// modulus below two gives a zero result without any multiplication.
// The result sits in an output register (out_valid, out_stall); a stalled
// result holds, and the next request may be taken meanwhile, but the engine
// waits at its end until the output register is free.
// Reset loads the register defaults (modulus 7879, generator 2, keys 1) and
// empties the engine and the output register.
module elgamal_cipher_engine
#(
    parameter int MOD_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] message,
    input  logic [31:0] nonce,
    input  logic [31:0] cipher_first,
    input  logic [31:0] cipher_second,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_first,
    output logic [31:0] result_second
);

    import egc_pkg::*;

    localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);

    logic [MOD_BITS-1:0] modulus_reg;
    logic [MOD_BITS-1:0] generator_reg;
    logic [MOD_BITS-1:0] public_key_reg;
    logic [MOD_BITS-1:0] private_key_reg;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic                cmd_reg, cmd_next;
    logic [MOD_BITS-1:0] msg_reg, msg_next;
    logic [MOD_BITS-1:0] nonce_reg, nonce_next;
    logic [MOD_BITS-1:0] c1_reg, c1_next;
    logic [MOD_BITS-1:0] base_reg, base_next;
    logic [MOD_BITS-1:0] exp_reg, exp_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] sav_reg, sav_next;
    logic [MOD_BITS-1:0] r1_reg, r1_next;
    logic [MOD_BITS-1:0] r2_reg, r2_next;
    logic                out_valid_reg, out_valid_next;
    logic [MOD_BITS-1:0] out_first_reg, out_first_next;
    logic [MOD_BITS-1:0] out_second_reg, out_second_next;

    logic                mul_start;
    logic [MOD_BITS-1:0] mul_a;
    logic [MOD_BITS-1:0] mul_b;
    logic                mul_done;
    logic [MOD_BITS-1:0] mul_res;
    logic                accept;

    egc_modmul #(.MOD_BITS(MOD_BITS)) u_modmul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .p       (modulus_reg),
        .done    (mul_done),
        .product (mul_res)
    );

    // Configuration registers, masked to the operand width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= RESET_MODULUS[MOD_BITS-1:0];
            generator_reg   <= RESET_GENERATOR[MOD_BITS-1:0];
            public_key_reg  <= RESET_PUBLIC_KEY[MOD_BITS-1:0];
            private_key_reg <= RESET_PRIVATE_KEY[MOD_BITS-1:0];
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODULUS:     modulus_reg     <= cfg_data[MOD_BITS-1:0];
                REG_GENERATOR:   generator_reg   <= cfg_data[MOD_BITS-1:0];
                REG_PUBLIC_KEY:  public_key_reg  <= cfg_data[MOD_BITS-1:0];
                REG_PRIVATE_KEY: private_key_reg <= cfg_data[MOD_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // Sequencer: reductions, square-and-multiply loops and final products.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        msg_next        = msg_reg;
        nonce_next      = nonce_reg;
        c1_next         = c1_reg;
        base_next       = base_reg;
        exp_next        = exp_reg;
        acc_next        = acc_reg;
        sav_next        = sav_reg;
        r1_next         = r1_reg;
        r2_next         = r2_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mul_start       = 1'b0;
        mul_a           = ONE;
        mul_b           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = command;
                    msg_next   = (command == CMD_DECRYPT) ? cipher_second[MOD_BITS-1:0]
                                                          : message[MOD_BITS-1:0];
                    nonce_next = nonce[MOD_BITS-1:0];
                    c1_next    = cipher_first[MOD_BITS-1:0];
                    if (modulus_reg < MOD_BITS'(2))
                    begin
                        r1_next    = '0;
                        r2_next    = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // Reduce the message or c2 below the modulus.
                        mul_start  = 1'b1;
                        mul_b      = msg_next;
                        state_next = ST_RED_MSG;
                    end
                end
            end

            ST_RED_MSG:
            begin
                if (mul_done)
                begin
                    sav_next   = mul_res;
                    phase_next = (cmd_reg == CMD_DECRYPT) ? PH_DEC_S : PH_ENC_G;
                    mul_start  = 1'b1;
                    mul_b      = (cmd_reg == CMD_DECRYPT) ? c1_reg : generator_reg;
                    state_next = ST_RED_BASE;
                end
            end

            ST_RED_BASE:
            begin
                if (mul_done)
                begin
                    base_next = mul_res;
                    acc_next  = ONE;
                    unique case (phase_reg)
                        PH_ENC_G,
                        PH_ENC_Y:   exp_next = nonce_reg;
                        PH_DEC_S:   exp_next = private_key_reg;
                        PH_DEC_INV: exp_next = modulus_reg - MOD_BITS'(2);
                        default:    exp_next = nonce_reg;
                    endcase
                    state_next = ST_POW_TEST;
                end
            end

            ST_POW_TEST:
            begin
                if (exp_reg == '0)
                begin
                    unique case (phase_reg)
                        PH_ENC_G:
                        begin
                            r1_next    = acc_reg;
                            phase_next = PH_ENC_Y;
                            mul_start  = 1'b1;
                            mul_b      = public_key_reg;
                            state_next = ST_RED_BASE;
                        end
                        PH_DEC_S:
                        begin
                            if (acc_reg == '0)
                            begin
                                // A zero shared secret has no inverse.
                                r1_next    = '0;
                                r2_next    = '0;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                phase_next = PH_DEC_INV;
                                mul_start  = 1'b1;
                                mul_b      = acc_reg;
                                state_next = ST_RED_BASE;
                            end
                        end
                        default:
                        begin
                            mul_start  = 1'b1;
                            mul_a      = acc_reg;
                            mul_b      = sav_reg;
                            state_next = ST_FIN_MUL;
                        end
                    endcase
                end
                else if (exp_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_a      = acc_reg;
                    mul_b      = base_reg;
                    state_next = ST_POW_ACC;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = base_reg;
                    mul_b      = base_reg;
                    state_next = ST_POW_SQ;
                end
            end

            ST_POW_ACC:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_res;
                    mul_start  = 1'b1;
                    mul_a      = base_reg;
                    mul_b      = base_reg;
                    state_next = ST_POW_SQ;
                end
            end

            ST_POW_SQ:
            begin
                if (mul_done)
                begin
                    base_next  = mul_res;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_POW_TEST;
                end
            end

            ST_FIN_MUL:
            begin
                if (mul_done)
                begin
                    if (phase_reg == PH_ENC_Y)
                    begin
                        r2_next = mul_res;
                    end
                    else
                    begin
                        r1_next = mul_res;
                        r2_next = '0;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hand over once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_first_next  = r1_reg;
                    out_second_next = r2_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_ENC_G;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        msg_reg        <= msg_next;
        nonce_reg      <= nonce_next;
        c1_reg         <= c1_next;
        base_reg       <= base_next;
        exp_reg        <= exp_next;
        acc_reg        <= acc_next;
        sav_reg        <= sav_next;
        r1_reg         <= r1_next;
        r2_reg         <= r2_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_first  = 32'(out_first_reg);
    assign result_second = 32'(out_second_reg);

endmodule

// ===== src/egc_cell.sv =====
// One bit cell of the multiplier operand chain.
// Depends on nothing; instantiated in a row by egc_modmul.
module egc_cell
(
    input  logic clk,
    input  logic load,
    input  logic shift,
    input  logic load_bit,
    input  logic prev_bit,
    output logic bit_out
);

    logic bit_reg;
    logic bit_next;

    // Take a fresh operand bit on load, otherwise the neighbour's bit on shift.
    always_comb
    begin
        bit_next = bit_reg;
        if (load)
        begin
            bit_next = load_bit;
        end
        else if (shift)
        begin
            bit_next = prev_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    assign bit_out = bit_reg;

endmodule

// ===== src/egc_modmul.sv =====
// Bit-serial modular multiplier: a * b mod p, one bit of b per cycle, MSB first.
// Depends on egc_cell; requires a < p and p >= 2.
module egc_modmul
#(
    parameter int MOD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MOD_BITS-1:0] a,
    input  logic [MOD_BITS-1:0] b,
    input  logic [MOD_BITS-1:0] p,
    output logic                done,
    output logic [MOD_BITS-1:0] product
);

    localparam int CW = $clog2(MOD_BITS);

    logic                busy_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] acc_next;
    logic [MOD_BITS-1:0] a_reg;
    logic [MOD_BITS-1:0] p_reg;
    logic [MOD_BITS-1:0] chain;
    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS:0]   dbl_red;
    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS:0]   sum_red;
    logic [MOD_BITS:0]   p_ext;

    // Row of cells holding b, shifting towards the top cell each busy cycle.
    for (genvar i = 0; i < MOD_BITS; i++)
    begin : g_cells
        egc_cell u_cell
        (
            .clk      (clk),
            .load     (start),
            .shift    (busy_reg),
            .load_bit (b[i]),
            .prev_bit ((i == 0) ? 1'b0 : chain[(i == 0) ? 0 : i-1]),
            .bit_out  (chain[i])
        );
    end

    // One Horner step: acc = 2*acc + bit*a, reduced after each addition.
    always_comb
    begin
        p_ext    = {1'b0, p_reg};
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= p_ext) ? (dbl - p_ext) : dbl;
        sum      = dbl_red + (chain[MOD_BITS-1] ? {1'b0, a_reg} : '0);
        sum_red  = (sum >= p_ext) ? (sum - p_ext) : sum;
        acc_next = sum_red[MOD_BITS-1:0];
    end

    // Control: step counter, busy and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MOD_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            p_reg   <= p;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== src/egc_checker.sv =====
// Port-level checker of the ElGamal engine and its bind to the top level.
// Depends on elgamal_cipher_engine_defines.svh.
`include "elgamal_cipher_engine_defines.svh"

module egc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_first,
    input logic [31:0] result_second
);

    // A stalled result stays offered.
    `EGC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // A stalled result keeps its value.
    `EGC_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                     $stable(result_first) && $stable(result_second))

    // Once a request is taken the engine is busy in the next cycle.
    `EGC_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)

    // No result can appear in the cycle straight after a request.
    `EGC_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid))

    // Results are reduced below the modulus, so never all ones.
    `EGC_ASSERT_NOW(a_result_range, out_valid,
                    (result_first != 32'hFFFF_FFFF) && (result_second != 32'hFFFF_FFFF))

endmodule

bind elgamal_cipher_engine egc_checker u_egc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_first  (result_first),
    .result_second (result_second)
);

// ===== tb/sv/elgamal_cipher_engine_test.sv =====
// Self-checking testbench for the ElGamal engine: encrypt and decrypt requests
// are predicted with square-and-multiply arithmetic and compared field by field.
// Depends on egc_pkg and elgamal_cipher_engine.
module elgamal_cipher_engine_test;
    import egc_pkg::*;

    // One predicted result of the engine.
    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
    } cipher_pair_t;

    // Scoreboard: predicts results from the register copy and checks them in order.
    class cipher_scoreboard;
        logic [31:0] p_mod;
        logic [31:0] gen;
        logic [31:0] pub_key;
        logic [31:0] priv_key;
        cipher_pair_t pending[$];
        int errors;

        function new();
            p_mod = RESET_MODULUS;
            gen = RESET_GENERATOR;
            pub_key = RESET_PUBLIC_KEY;
            priv_key = RESET_PRIVATE_KEY;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_MODULUS:     p_mod = val;
                REG_GENERATOR:   gen = val;
                REG_PUBLIC_KEY:  pub_key = val;
                REG_PRIVATE_KEY: priv_key = val;
                default: ;
            endcase
        endfunction

        function logic [63:0] power_mod(logic [63:0] b, logic [63:0] e, logic [63:0] p);
            logic [63:0] acc;
            logic [63:0] sq;
            acc = 64'd1 % p;
            sq = b % p;
            while (e != 0)
            begin
                if (e[0])
                    acc = (acc * sq) % p;
                e = e >> 1;
                sq = (sq * sq) % p;
            end
            return acc;
        endfunction

        // Note an accepted request and queue its expected result.
        function void note_request(logic cmd, logic [31:0] msg, logic [31:0] k,
                                   logic [31:0] c1, logic [31:0] c2);
            cipher_pair_t r;
            logic [63:0] p;
            logic [63:0] s;
            r = '0;
            p = p_mod;
            if (p >= 2)
            begin
                if (cmd == CMD_ENCRYPT)
                begin
                    r.first = 32'(power_mod(gen, k, p));
                    r.second = 32'((power_mod(pub_key, k, p) * (msg % p)) % p);
                end
                else
                begin
                    s = power_mod(c1, priv_key, p);
                    if (s != 0)
                        r.first = 32'(((c2 % p) * power_mod(s, p - 2, p)) % p);
                end
            end
            pending.push_back(r);
        endfunction

        // Compare an accepted result with the oldest expectation.
        function void check_result(logic [31:0] f, logic [31:0] s);
            cipher_pair_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h %h", $time, f, s);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (f !== e.first)
            begin
                $display("%0t: result_first expected %h actual %h", $time, e.first, f);
                errors++;
            end
            if (s !== e.second)
            begin
                $display("%0t: result_second expected %h actual %h", $time, e.second, s);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [31:0] message;
    logic [31:0] nonce;
    logic [31:0] cipher_first;
    logic [31:0] cipher_second;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_first;
    logic [31:0] result_second;

    cipher_scoreboard board;
    int  idle_cycles;
    bit  sink_busy_mode;
    bit  hold_off_req;
    bit  timed_out;

    elgamal_cipher_engine dut
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .message(message), .nonce(nonce),
        .cipher_first(cipher_first), .cipher_second(cipher_second),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_first(result_first), .result_second(result_second)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result side: random stall, quiet stretch, and one long hold-off.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                for (hold = 0; hold < 20000; hold++)
                    @(negedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (sink_busy_mode)
                out_stall <= ($urandom_range(99) < 26);
            else
                out_stall <= 1'b0;
        end
    end

    // Check each accepted result; the watchdog counts cycles with no transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(result_first, result_second);
        if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 100000)
            timed_out <= 1'b1;
    end

    initial
    begin
        wait (timed_out);
        $display("FAILURE");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.write_reg(idx, val);
    endtask

    task automatic set_keys(logic [31:0] p, logic [31:0] g, logic [31:0] y, logic [31:0] x);
        write_reg(REG_MODULUS, p);
        write_reg(REG_GENERATOR, g);
        write_reg(REG_PUBLIC_KEY, y);
        write_reg(REG_PRIVATE_KEY, x);
    endtask

    // Offer one request, possibly after a random gap, and wait for acceptance.
    // Valid stays high after acceptance until the next request or a drain.
    task automatic send_request(logic cmd, logic [31:0] msg, logic [31:0] k,
                                logic [31:0] c1, logic [31:0] c2, bit gaps);
        while (gaps && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        message <= msg;
        nonce <= k;
        cipher_first <= c1;
        cipher_second <= c2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(cmd, msg, k, c1, c2);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return 32'hFFFF_FFFF - $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request(logic [31:0] p, bit gaps);
        logic [31:0] k;
        logic [31:0] m;
        k = ($urandom_range(3) == 0) ? rand_word() : $urandom_range(1, p > 3 ? p - 2 : 1);
        m = ($urandom_range(3) == 0) ? rand_word() : $urandom % p;
        if ($urandom_range(1) == 0)
            send_request(CMD_ENCRYPT, m, k, rand_word(), rand_word(), gaps);
        else
            send_request(CMD_DECRYPT, rand_word(), rand_word(),
                         ($urandom_range(2) == 0) ? rand_word() : $urandom % p,
                         ($urandom_range(2) == 0) ? rand_word() : $urandom % p, gaps);
    endtask

    // Stimulus sequence.
    initial
    begin
        int n;
        board = new();
        idle_cycles = 0;
        timed_out = 1'b0;
        sink_busy_mode = 1'b0;
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MODULUS;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_ENCRYPT;
        message = '0;
        nonce = '0;
        cipher_first = '0;
        cipher_second = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset keys, zero exponent, large operands, both commands.
        send_request(CMD_ENCRYPT, 32'd1234, 32'd5, '0, '0, 0);
        send_request(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'd0, '0, '0, 0);
        send_request(CMD_ENCRYPT, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(CMD_DECRYPT, '0, '0, 32'd123, 32'd456, 0);
        send_request(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 32'd77, 0);
        send_request(CMD_DECRYPT, '0, '0, 32'd7879, 32'hFFFF_FFFF, 0);
        drain();

        // Small group: p = 23, g = 5, x = 6, y = 8.
        set_keys(32'd23, 32'd5, 32'd8, 32'd6);
        send_request(CMD_ENCRYPT, 32'd10, 32'd3, '0, '0, 0);
        send_request(CMD_DECRYPT, '0, '0, 32'd10, 32'd13, 0);
        send_request(CMD_DECRYPT, '0, '0, 32'd46, 32'd13, 0);
        drain();

        // Modulus below two, then modulus one.
        set_keys(32'd0, 32'd3, 32'd2, 32'd5);
        send_request(CMD_ENCRYPT, 32'd9, 32'd4, '0, '0, 0);
        send_request(CMD_DECRYPT, '0, '0, 32'd9, 32'd4, 0);
        drain();
        write_reg(REG_MODULUS, 32'd1);
        send_request(CMD_ENCRYPT, 32'd9, 32'd4, '0, '0, 0);
        drain();

        // Largest 32-bit prime with extreme keys.
        set_keys(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 0);
        send_request(CMD_DECRYPT, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(CMD_DECRYPT, '0, '0, '0, 32'd5, 0);
        drain();

        // Smallest odd prime modulus.
        set_keys(32'd3, 32'd2, 32'd2, 32'd1);
        send_request(CMD_ENCRYPT, 32'd2, 32'd1, '0, '0, 0);
        send_request(CMD_DECRYPT, '0, '0, 32'd2, 32'd1, 0);
        drain();

        // Random phases with no idling first, then random idling, with a hold-off.
        for (n = 0; n < 5; n++)
        begin
            logic [31:0] p;
            logic [31:0] x;
            int j;
            case (n)
                0: p = 32'd7879;
                1: p = 32'd65521;
                2: p = 32'hFFFF_FFFB;
                3: p = 32'd2147483647;
                default: p = 32'd1000003;
            endcase
            x = ($urandom_range(3) == 0) ? rand_word() : $urandom_range(1, p - 2);
            set_keys(p, $urandom_range(2, p - 1),
                     32'(board.power_mod($urandom_range(2, p - 1), x, p)), x);
            sink_busy_mode = (n >= 1);
            if (n == 2)
                hold_off_req = 1'b1;
            for (j = 0; j < 22; j++)
                random_request(p, n >= 1);
            drain();
        end

        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
